FILE: sv/qrap_pkg.sv
// qrap_pkg: payload types, widths and helpers for the quaternion pivot rotation unit
// no dependencies

package qrap_pkg;

   localparam int QuatWidth   = 16;
   localparam int CoordWidth  = 32;
   localparam int DiffWidth   = CoordWidth + 1;
   localparam int ProdWidth   = 2 * QuatWidth + 1;
   localparam int MatWidth    = ProdWidth + 1;
   localparam int DLoWidth    = 16;
   localparam int DHiWidth    = DiffWidth - DLoWidth;
   localparam int PartWidth   = MatWidth + DHiWidth;
   localparam int SumWidth    = PartWidth + 2;
   localparam int FracShift   = 28;
   localparam int TotWidth    = SumWidth + DLoWidth + 1;
   localparam int RndWidth    = TotWidth - FracShift;
   localparam int FinWidth    = RndWidth + 1;

   localparam logic signed [MatWidth-1:0] OneQ28    = MatWidth'(1) <<< FracShift;
   localparam logic signed [TotWidth-1:0] RoundBias = TotWidth'(1) <<< (FracShift - 1);
   localparam logic signed [FinWidth-1:0] CoordMax  = FinWidth'(2147483647);
   localparam logic signed [FinWidth-1:0] CoordMin  = -(FinWidth'(64'sd2147483648));

   typedef struct packed {
      logic signed [QuatWidth-1:0]  quat_x;
      logic signed [QuatWidth-1:0]  quat_y;
      logic signed [QuatWidth-1:0]  quat_z;
      logic signed [QuatWidth-1:0]  quat_w;
      logic signed [CoordWidth-1:0] point_x;
      logic signed [CoordWidth-1:0] point_y;
      logic signed [CoordWidth-1:0] point_z;
      logic signed [CoordWidth-1:0] pivot_x;
      logic signed [CoordWidth-1:0] pivot_y;
      logic signed [CoordWidth-1:0] pivot_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] out_x;
      logic signed [CoordWidth-1:0] out_y;
      logic signed [CoordWidth-1:0] out_z;
      logic                         saturated;
   } rsp_type;

   // doubled product of two quaternion components, exact
   function automatic logic signed [ProdWidth-1:0] dbl_mul(
      input logic signed [QuatWidth-1:0] a,
      input logic signed [QuatWidth-1:0] b
   );
      logic signed [2*QuatWidth-1:0] p;
      p = a * b;
      return {p, 1'b0};
   endfunction

   function automatic logic signed [MatWidth-1:0] mat_ext(
      input logic signed [ProdWidth-1:0] v
   );
      return {v[ProdWidth-1], v};
   endfunction

   function automatic logic signed [DiffWidth-1:0] diff(
      input logic signed [CoordWidth-1:0] a,
      input logic signed [CoordWidth-1:0] b
   );
      return $signed({a[CoordWidth-1], a}) - $signed({b[CoordWidth-1], b});
   endfunction

endpackage

FILE: sv/quaternion_rotate_about_pivot_unit.sv
// quaternion_rotate_about_pivot_unit: rotates a point about a pivot by a quaternion
// six-stage pipeline; depends on qrap_pkg
//
// usage: an item on req_data (quaternion Q2.14, point and pivot Q16.16) is taken
// when req_valid and req_ready are both high. the rotated point, saturated to
// 32 bits with a flag, is offered on rsp_data under rsp_valid and is taken when
// rsp_valid and rsp_ready are both high.
// an item taken passes through every stage register in order to the output
// register. throughput: one item per cycle while rsp_ready stays high.
// the six stages are: component products and difference, matrix entries,
// split partial products of the 34 by 33 bit dot products, row sums,
// rounding, pivot add and clipping. the 17 bit partial multipliers set the
// depth of the longest stage.
// stall: a full stage holds while the next one is full and stalled, so empty stages
// still fill; req_ready stays high until all stages are full and rsp_ready is low.
// reset: synchronous, clears every stage valid bit; nothing in flight survives.

module quaternion_rotate_about_pivot_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qrap_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qrap_pkg::rsp_type rsp_data
);

   localparam int NumStages = 6;

   logic [NumStages-1:0] v_ff;
   logic [NumStages-1:0] en;

   // stage 1: doubled products, difference
   logic signed [qrap_pkg::ProdWidth-1:0]  xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [qrap_pkg::ProdWidth-1:0]  wx_ff, wy_ff, wz_ff;
   logic signed [qrap_pkg::DiffWidth-1:0]  d1_ff [3];
   logic signed [qrap_pkg::CoordWidth-1:0] pv1_ff [3];

   // stage 2: matrix
   logic signed [qrap_pkg::MatWidth-1:0]   mat_in [3][3];
   logic signed [qrap_pkg::MatWidth-1:0]   mat_ff [3][3];
   logic signed [qrap_pkg::DiffWidth-1:0]  d2_ff [3];
   logic signed [qrap_pkg::CoordWidth-1:0] pv2_ff [3];

   // stage 3: partial products
   logic signed [qrap_pkg::PartWidth-1:0]  ph_in [3][3];
   logic signed [qrap_pkg::PartWidth-1:0]  pl_in [3][3];
   logic signed [qrap_pkg::PartWidth-1:0]  ph_ff [3][3];
   logic signed [qrap_pkg::PartWidth-1:0]  pl_ff [3][3];
   logic signed [qrap_pkg::CoordWidth-1:0] pv3_ff [3];

   // stage 4: row sums
   logic signed [qrap_pkg::SumWidth-1:0]   hs_in [3];
   logic signed [qrap_pkg::SumWidth-1:0]   ls_in [3];
   logic signed [qrap_pkg::SumWidth-1:0]   hs_ff [3];
   logic signed [qrap_pkg::SumWidth-1:0]   ls_ff [3];
   logic signed [qrap_pkg::CoordWidth-1:0] pv4_ff [3];

   // stage 5: rounded
   logic signed [qrap_pkg::TotWidth-1:0]   tot [3];
   logic signed [qrap_pkg::RndWidth-1:0]   rnd_in [3];
   logic signed [qrap_pkg::RndWidth-1:0]   rnd_ff [3];
   logic signed [qrap_pkg::CoordWidth-1:0] pv5_ff [3];

   // stage 6: output
   logic signed [qrap_pkg::FinWidth-1:0]   fin [3];
   logic signed [qrap_pkg::CoordWidth-1:0] clip_in [3];
   logic [2:0]                             sat_in;
   qrap_pkg::rsp_type                      rsp_ff;

   // stall chain
   always_comb begin
      en[NumStages-1] = !v_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NumStages-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (en[0]) begin
         xx_ff     <= qrap_pkg::dbl_mul(req_data.quat_x, req_data.quat_x);
         yy_ff     <= qrap_pkg::dbl_mul(req_data.quat_y, req_data.quat_y);
         zz_ff     <= qrap_pkg::dbl_mul(req_data.quat_z, req_data.quat_z);
         xy_ff     <= qrap_pkg::dbl_mul(req_data.quat_x, req_data.quat_y);
         xz_ff     <= qrap_pkg::dbl_mul(req_data.quat_x, req_data.quat_z);
         yz_ff     <= qrap_pkg::dbl_mul(req_data.quat_y, req_data.quat_z);
         wx_ff     <= qrap_pkg::dbl_mul(req_data.quat_w, req_data.quat_x);
         wy_ff     <= qrap_pkg::dbl_mul(req_data.quat_w, req_data.quat_y);
         wz_ff     <= qrap_pkg::dbl_mul(req_data.quat_w, req_data.quat_z);
         d1_ff[0]  <= qrap_pkg::diff(req_data.point_x, req_data.pivot_x);
         d1_ff[1]  <= qrap_pkg::diff(req_data.point_y, req_data.pivot_y);
         d1_ff[2]  <= qrap_pkg::diff(req_data.point_z, req_data.pivot_z);
         pv1_ff[0] <= req_data.pivot_x;
         pv1_ff[1] <= req_data.pivot_y;
         pv1_ff[2] <= req_data.pivot_z;
      end
   end

   // stage 2
   always_comb begin
      mat_in[0][0] = qrap_pkg::OneQ28
                     - (qrap_pkg::mat_ext(yy_ff) + qrap_pkg::mat_ext(zz_ff));
      mat_in[0][1] = qrap_pkg::mat_ext(xy_ff) - qrap_pkg::mat_ext(wz_ff);
      mat_in[0][2] = qrap_pkg::mat_ext(xz_ff) + qrap_pkg::mat_ext(wy_ff);
      mat_in[1][0] = qrap_pkg::mat_ext(xy_ff) + qrap_pkg::mat_ext(wz_ff);
      mat_in[1][1] = qrap_pkg::OneQ28
                     - (qrap_pkg::mat_ext(xx_ff) + qrap_pkg::mat_ext(zz_ff));
      mat_in[1][2] = qrap_pkg::mat_ext(yz_ff) - qrap_pkg::mat_ext(wx_ff);
      mat_in[2][0] = qrap_pkg::mat_ext(xz_ff) - qrap_pkg::mat_ext(wy_ff);
      mat_in[2][1] = qrap_pkg::mat_ext(yz_ff) + qrap_pkg::mat_ext(wx_ff);
      mat_in[2][2] = qrap_pkg::OneQ28
                     - (qrap_pkg::mat_ext(xx_ff) + qrap_pkg::mat_ext(yy_ff));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         mat_ff <= mat_in;
         d2_ff  <= d1_ff;
         pv2_ff <= pv1_ff;
      end
   end

   // stage 3: difference split into signed high and unsigned low halves
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            ph_in[i][k] = mat_ff[i][k]
               * $signed(d2_ff[k][qrap_pkg::DiffWidth-1:qrap_pkg::DLoWidth]);
            pl_in[i][k] = mat_ff[i][k]
               * $signed({1'b0, d2_ff[k][qrap_pkg::DLoWidth-1:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ph_ff  <= ph_in;
         pl_ff  <= pl_in;
         pv3_ff <= pv2_ff;
      end
   end

   // stage 4
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hs_in[i] = qrap_pkg::SumWidth'(ph_ff[i][0]) + qrap_pkg::SumWidth'(ph_ff[i][1])
                    + qrap_pkg::SumWidth'(ph_ff[i][2]);
         ls_in[i] = qrap_pkg::SumWidth'(pl_ff[i][0]) + qrap_pkg::SumWidth'(pl_ff[i][1])
                    + qrap_pkg::SumWidth'(pl_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         hs_ff  <= hs_in;
         ls_ff  <= ls_in;
         pv4_ff <= pv3_ff;
      end
   end

   // stage 5: round half up to q16.16
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tot[i]    = (qrap_pkg::TotWidth'(hs_ff[i]) <<< qrap_pkg::DLoWidth)
                     + qrap_pkg::TotWidth'(ls_ff[i]) + qrap_pkg::RoundBias;
         rnd_in[i] = tot[i][qrap_pkg::TotWidth-1:qrap_pkg::FracShift];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rnd_ff <= rnd_in;
         pv5_ff <= pv4_ff;
      end
   end

   // stage 6: pivot back, clip
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin[i] = qrap_pkg::FinWidth'(rnd_ff[i]) + qrap_pkg::FinWidth'(pv5_ff[i]);
         if (fin[i] > qrap_pkg::CoordMax) begin
            clip_in[i] = qrap_pkg::CoordMax[qrap_pkg::CoordWidth-1:0];
            sat_in[i]  = 1'b1;
         end else if (fin[i] < qrap_pkg::CoordMin) begin
            clip_in[i] = qrap_pkg::CoordMin[qrap_pkg::CoordWidth-1:0];
            sat_in[i]  = 1'b1;
         end else begin
            clip_in[i] = fin[i][qrap_pkg::CoordWidth-1:0];
            sat_in[i]  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         rsp_ff.out_x     <= clip_in[0];
         rsp_ff.out_y     <= clip_in[1];
         rsp_ff.out_z     <= clip_in[2];
         rsp_ff.saturated <= |sat_in;
      end
   end

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline stalled while the receiver takes items");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_ready)
      else $error("first stage empty but item refused");

   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      v_ff[NumStages-2] && en[NumStages-1] |=> rsp_valid)
      else $error("item lost entering the output register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

FILE: sim/tb_quaternion_rotate_about_pivot_unit.sv
// tb_quaternion_rotate_about_pivot_unit: self-checking bench for the quaternion pivot rotation
// unit; a scoreboard class predicts each rotated point; depends on qrap_pkg and the unit itself

module tb_quaternion_rotate_about_pivot_unit;

   typedef logic signed [79:0] wide_type;

   localparam int RandomItems = 1750;
   localparam int QuietLimit  = 2000;
   localparam int Settle      = 12;
   localparam int ReportLimit = 10;
   localparam int CoordHi     = 2147483647;
   localparam int CoordLo     = -2147483647 - 1;
   localparam int QuatHi      = 32767;
   localparam int QuatLo      = -32768;
   localparam int QuatOne     = 16384;
   localparam int Cos45       = 11585;

   typedef enum int {UnitNear, UnitFar, RawBits, NoPivot, EdgeQuat} item_kind_type;

   class rotation_scoreboard;
      qrap_pkg::rsp_type expected_points[$];
      int      mismatches;

      function qrap_pkg::rsp_type rotate_about_pivot(qrap_pkg::req_type r);
         longint  qx, qy, qz, qw;
         longint  xx, yy, zz, xy, xz, yz, wx, wy, wz;
         longint  m[3][3];
         longint  c[3];
         longint  d[3];
         wide_type acc;
         qrap_pkg::rsp_type res;
         logic signed [31:0] clipped[3];
         logic    sat;
         qx = $signed(r.quat_x);
         qy = $signed(r.quat_y);
         qz = $signed(r.quat_z);
         qw = $signed(r.quat_w);
         c[0] = $signed(r.pivot_x);
         c[1] = $signed(r.pivot_y);
         c[2] = $signed(r.pivot_z);
         d[0] = longint'($signed(r.point_x)) - c[0];
         d[1] = longint'($signed(r.point_y)) - c[1];
         d[2] = longint'($signed(r.point_z)) - c[2];
         xx = 2 * qx * qx;  yy = 2 * qy * qy;  zz = 2 * qz * qz;
         xy = 2 * qx * qy;  xz = 2 * qx * qz;  yz = 2 * qy * qz;
         wx = 2 * qw * qx;  wy = 2 * qw * qy;  wz = 2 * qw * qz;
         m[0][0] = (longint'(1) <<< 28) - (yy + zz);
         m[0][1] = xy - wz;
         m[0][2] = xz + wy;
         m[1][0] = xy + wz;
         m[1][1] = (longint'(1) <<< 28) - (xx + zz);
         m[1][2] = yz - wx;
         m[2][0] = xz - wy;
         m[2][1] = yz + wx;
         m[2][2] = (longint'(1) <<< 28) - (xx + yy);
         sat = 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
               acc = acc + wide_type'(m[i][k]) * wide_type'(d[k]);
            end
            // round half up to q16.16, then put the pivot back
            acc = (acc + (wide_type'(1) <<< 27)) >>> 28;
            acc = acc + wide_type'(c[i]);
            if (acc > wide_type'(CoordHi)) begin
               sat = 1'b1;
               acc = wide_type'(CoordHi);
            end else if (acc < wide_type'(CoordLo)) begin
               sat = 1'b1;
               acc = wide_type'(CoordLo);
            end
            clipped[i] = acc[31:0];
         end
         res.out_x     = clipped[0];
         res.out_y     = clipped[1];
         res.out_z     = clipped[2];
         res.saturated = sat;
         return res;
      endfunction

      function void note_request(qrap_pkg::req_type r);
         expected_points.push_back(rotate_about_pivot(r));
      endfunction

      function void flag(string field, longint want, longint got);
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("%s mismatch: expected %0d, got %0d", field, want, got);
      endfunction

      function void check_result(qrap_pkg::rsp_type got);
         qrap_pkg::rsp_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("unexpected result: out_x %0d out_y %0d out_z %0d sat %0d",
                        got.out_x, got.out_y, got.out_z, got.saturated);
            return;
         end
         want = expected_points.pop_front();
         if (got.out_x !== want.out_x) flag("out_x", want.out_x, got.out_x);
         if (got.out_y !== want.out_y) flag("out_y", want.out_y, got.out_y);
         if (got.out_z !== want.out_z) flag("out_z", want.out_z, got.out_z);
         if (got.saturated !== want.saturated) flag("saturated", want.saturated, got.saturated);
      endfunction

      function int waiting();
         return expected_points.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   qrap_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   qrap_pkg::rsp_type rsp_data;

   rotation_scoreboard board = new;
   bit no_gaps = 1'b0;
   int quiet   = 0;

   quaternion_rotate_about_pivot_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // mostly short, now and then long
   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic qrap_pkg::req_type make_item(int qx, int qy, int qz, int qw,
                                                   int px, int py, int pz,
                                                   int cx, int cy, int cz);
      qrap_pkg::req_type r;
      r.quat_x  = qx[15:0];
      r.quat_y  = qy[15:0];
      r.quat_z  = qz[15:0];
      r.quat_w  = qw[15:0];
      r.point_x = px;
      r.point_y = py;
      r.point_z = pz;
      r.pivot_x = cx;
      r.pivot_y = cy;
      r.pivot_z = cz;
      return r;
   endfunction

   function automatic int random_coord(int lo_shift, int hi_shift);
      int v;
      v = $urandom();
      return v >>> $urandom_range(lo_shift, hi_shift);
   endfunction

   function automatic int edge_component();
      int v;
      case ($urandom_range(5))
         0: v = QuatLo;
         1: v = QuatHi;
         2: v = 0;
         3: v = QuatOne;
         4: v = -QuatOne;
         default: begin
            v = $urandom_range(65535);
            v = v - 32768;
         end
      endcase
      return v;
   endfunction

   function automatic qrap_pkg::req_type random_item();
      item_kind_type     kind;
      qrap_pkg::req_type r;
      real               ax, ay, az, n, h, s;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 40)      kind = UnitNear;
      else if (pick < 55) kind = UnitFar;
      else if (pick < 75) kind = RawBits;
      else if (pick < 88) kind = NoPivot;
      else                kind = EdgeQuat;
      r = make_item($urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom());
      if (kind != RawBits) begin
         // unit quaternion from a random axis and angle
         ax = $itor($urandom_range(2000)) - 1000.0;
         ay = $itor($urandom_range(2000)) - 1000.0;
         az = $itor($urandom_range(2000)) - 1000.0;
         n  = $sqrt(ax * ax + ay * ay + az * az);
         if (n < 1.0) begin
            ax = 1.0;
            n  = 1.0;
         end
         h = $itor($urandom_range(62831)) / 20000.0;
         s = $sin(h);
         r.quat_x = 16'($rtoi(s * ax / n * 16384.0));
         r.quat_y = 16'($rtoi(s * ay / n * 16384.0));
         r.quat_z = 16'($rtoi(s * az / n * 16384.0));
         r.quat_w = 16'($rtoi($cos(h) * 16384.0));
      end
      case (kind)
         UnitNear, NoPivot: begin
            r.point_x = random_coord(6, 24);
            r.point_y = random_coord(6, 24);
            r.point_z = random_coord(6, 24);
            r.pivot_x = random_coord(6, 24);
            r.pivot_y = random_coord(6, 24);
            r.pivot_z = random_coord(6, 24);
            if (kind == NoPivot) begin
               r.pivot_x = '0;
               r.pivot_y = '0;
               r.pivot_z = '0;
            end
         end
         UnitFar: begin
            r.point_x = random_coord(0, 2);
            r.point_y = random_coord(0, 2);
            r.point_z = random_coord(0, 2);
         end
         EdgeQuat: begin
            r.quat_x = 16'(edge_component());
            r.quat_y = 16'(edge_component());
            r.quat_z = 16'(edge_component());
            r.quat_w = 16'(edge_component());
            r.point_x = random_coord(0, 24);
            r.point_y = random_coord(0, 24);
            r.point_z = random_coord(0, 24);
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input qrap_pkg::req_type item);
      int gap;
      gap = 0;
      if (!no_gaps && $urandom_range(99) >= 55) gap = gap_length();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_pipeline();
      @(negedge clock) req_valid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
      if (quiet == QuietLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (no_gaps) begin
            rsp_ready <= 1'b1;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(99) < 20) stall_left = gap_length();
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(0, 0, 0, QuatOne, 1 << 16, 2 << 16, 3 << 16, 0, 0, 0));
      // zero quaternion is the identity; widest point to pivot difference
      send_item(make_item(0, 0, 0, 0, CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo));
      send_item(make_item(0, 0, 0, 0, CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi));
      send_item(make_item(QuatHi, QuatHi, QuatHi, QuatHi,
                          CoordHi, CoordLo, CoordHi, CoordLo, CoordHi, CoordLo));
      send_item(make_item(QuatLo, QuatLo, QuatLo, QuatLo,
                          CoordLo, CoordHi, CoordLo, CoordHi, CoordLo, CoordHi));
      send_item(make_item(QuatLo, 0, 0, 0, 5 << 16, -7 << 16, 9 << 16, 1, -1, 1));
      // quarter turns about each axis around an offset pivot, then a half turn about z
      send_item(make_item(Cos45, 0, 0, Cos45, 0, 1 << 16, 0, 5 << 16, 5 << 16, 5 << 16));
      send_item(make_item(0, Cos45, 0, Cos45, 0, 0, 1 << 16, 5 << 16, 5 << 16, 5 << 16));
      send_item(make_item(0, 0, Cos45, Cos45, 1 << 16, 0, 0, 5 << 16, 5 << 16, 5 << 16));
      send_item(make_item(0, 0, QuatOne, 0, 3 << 16, -4 << 16, 6 << 16, 0, 0, 0));
      // exact halves round towards plus infinity
      send_item(make_item(0, 0, 64, 0, 1 << 14, 0, 0, 0, 0, 0));
      send_item(make_item(0, 0, 64, 0, -(1 << 14), 0, 0, 0, 0, 0));
      // non-unit quaternion shears and scales
      send_item(make_item(QuatOne, QuatOne, QuatOne, 0,
                          7 << 16, -3 << 16, 1 << 16, 12345, -54321, 777));
      // half turn about x flips y and z, clipping at both ends
      send_item(make_item(QuatOne, 0, 0, 0, 0, CoordLo, 0, 0, 0, 0));
      send_item(make_item(QuatOne, 0, 0, 0, 0, CoordHi, 0, 0, CoordLo, 0));
      send_item(make_item(QuatOne, 0, 0, 0, 0, 0, CoordLo, 0, 0, 0));
      send_item(make_item(QuatHi, QuatHi, QuatHi, QuatHi,
                          $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom()));

      for (int i = 0; i < RandomItems; i++) begin
         if (i == 600 || i == 1300) drain_pipeline();
         no_gaps = (i >= 900 && i < 1100);
         send_item(random_item());
      end
      no_gaps = 1'b0;

      @(negedge clock) req_valid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
      if (board.mismatches == 0 && board.waiting() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
